>>> rtl/afs_pkg.sv
// shared constants, codes and types of the animation frame sequencer
// no dependencies; imported by afs_divider and the top level
package afs_pkg;

   localparam int FRAME_BITS = 16;
   localparam int N_BITS     = FRAME_BITS + 1;
   localparam int ACC_BITS   = 17;
   localparam int TIME_BITS  = 32;
   localparam int DIV_BITS   = 16;
   localparam int CNT_BITS   = $clog2(TIME_BITS);
   localparam int TICK_MS    = 10;

   localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};
   localparam logic [ACC_BITS-1:0]   ACC_MAX   = {ACC_BITS{1'b1}};

   localparam int IN_TDATA_W  = 56;
   localparam int OUT_TDATA_W = 24;
   localparam int OP_BITS     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_START = 2'd2;
   localparam logic [OP_BITS-1:0] OP_PAUSE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REBOUND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 3'd4;

   typedef struct packed {
      logic                 start;
      logic [TIME_BITS-1:0] dividend;
      logic [DIV_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [TIME_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

>>> rtl/afs_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on afs_pkg
module afs_divider
   import afs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0]  dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_BITS:0]    shifted;
   logic [DIV_BITS+1:0]  diff;
   logic                 qbit;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[TIME_BITS-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      qbit    = !diff[DIV_BITS+1];
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
         quo_in = {quo_ff[TIME_BITS-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(TIME_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> rtl/animation_frame_sequencer_unit.sv
// top level of the animation frame sequencer: control sequencer and frame state
// depends on afs_pkg and afs_divider
//
// One result per request. Load, start, pause and ignored ticks skip the update
// state; a step-mode tick enters it once the accumulator reaches the interval. A
// time-mode tick runs the elapsed time through the bit-serial divider, one
// quotient bit per cycle, and enters the update state when the frame moves. A new
// request is taken while the previous result still waits in the output register.
// Configuration writes are taken at any time but are meant for an idle block; each
// accepted write of a known register also clears the step accumulator.
module animation_frame_sequencer_unit
   import afs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_ms[31:0], frame_value[47:32], reverse_flag[48], zero fill
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  logic [OP_BITS-1:0]     req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // frame[15:0], ascending[16], done_res[17], running[18], changed[19], zero fill
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_UPD  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [OP_BITS-1:0]    op_ff, op_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [FRAME_BITS-1:0] fv_ff, fv_in;
   logic                  rev_ff, rev_in;

   logic [FRAME_BITS-1:0] interval_ff, interval_in;
   logic [FRAME_BITS-1:0] total_ff, total_in;
   logic                  loop_ff, loop_in;
   logic                  reb_ff, reb_in;
   logic                  step_ff, step_in;

   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  up_ff, up_in;
   logic                  done_ff, done_in;
   logic                  active_ff, active_in;
   logic                  held_ff, held_in;
   logic                  back_ff, back_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   logic [N_BITS-1:0]     n_ff, n_in;
   logic                  chg_ff, chg_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [ACC_BITS:0]     acc_sum;
   logic [ACC_BITS-1:0]   acc_sat;
   logic [N_BITS:0]       up_sum;
   logic [FRAME_BITS-1:0] fc1;
   logic                  neg;
   logic [N_BITS-1:0]     total_p1;
   logic [N_BITS-1:0]     restart;
   logic [FRAME_BITS-1:0] upd_frame;
   logic                  upd_up;
   logic                  upd_done;
   logic [N_BITS-1:0]     n_clamp;
   logic                  rsp_free;

   afs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // saturating step accumulator
   always_comb begin
      acc_sum = {1'b0, acc_ff} + (ACC_BITS+1)'(TICK_MS);
      acc_sat = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
   end

   // quotient limited to the range that can still move the frame
   assign n_clamp = (|div_rsp.quotient[TIME_BITS-1:N_BITS]) ? {N_BITS{1'b1}}
                                                              : div_rsp.quotient[N_BITS-1:0];

   // frame move and boundary rules
   always_comb begin
      neg      = 1'b0;
      up_sum   = {2'b00, frame_ff} + {1'b0, n_ff};
      total_p1 = {1'b0, total_ff} + 1'b1;
      restart  = (total_p1 > n_ff) ? (total_p1 - n_ff) : '0;
      if (up_ff) begin
         fc1 = (up_sum > {2'b00, FRAME_MAX}) ? FRAME_MAX : up_sum[FRAME_BITS-1:0];
      end else if (frame_ff == '0) begin
         neg = 1'b1;
         fc1 = '0;
      end else begin
         fc1 = ({1'b0, frame_ff} > n_ff) ? FRAME_BITS'({1'b0, frame_ff} - n_ff) : '0;
      end
      upd_frame = fc1;
      upd_up    = up_ff;
      upd_done  = done_ff;
      if (fc1 == '0) begin
         if (loop_ff && reb_ff) begin
            upd_up    = 1'b1;
            upd_frame = '0;
            upd_done  = 1'b0;
         end else if (loop_ff && back_ff) begin
            if (neg) begin
               upd_up    = 1'b0;
               upd_frame = step_ff ? total_ff : restart[FRAME_BITS-1:0];
               upd_done  = 1'b0;
            end
         end else begin
            upd_up    = 1'b0;
            upd_frame = '0;
            upd_done  = 1'b1;
         end
      end else if (fc1 >= total_ff) begin
         if (loop_ff && reb_ff) begin
            upd_up    = 1'b0;
            upd_frame = total_ff;
            upd_done  = 1'b0;
         end else if (loop_ff && !back_ff) begin
            if (fc1 > total_ff) begin
               upd_up    = 1'b1;
               upd_frame = '0;
               upd_done  = 1'b0;
            end
         end else begin
            upd_up    = 1'b1;
            upd_frame = total_ff;
            upd_done  = 1'b1;
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      fv_in        = fv_ff;
      rev_in       = rev_ff;
      interval_in  = interval_ff;
      total_in     = total_ff;
      loop_in      = loop_ff;
      reb_in       = reb_ff;
      step_in      = step_ff;
      frame_in     = frame_ff;
      up_in        = up_ff;
      done_in      = done_ff;
      active_in    = active_ff;
      held_in      = held_ff;
      back_in      = back_ff;
      acc_in       = acc_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      chg_in       = chg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      div_req.start    = 1'b0;
      div_req.dividend = now_ff - last_ff;
      div_req.divisor  = (interval_ff == '0) ? DIV_BITS'(1) : interval_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               now_in   = req_tdata[31:0];
               fv_in    = req_tdata[47:32];
               rev_in   = req_tdata[48];
               chg_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (op_ff)
               OP_TICK: begin
                  if (active_ff && !held_ff) begin
                     if (step_ff) begin
                        if (acc_sat < {1'b0, interval_ff}) begin
                           acc_in = acc_sat;
                        end else begin
                           acc_in   = '0;
                           n_in     = N_BITS'(1);
                           state_in = ST_UPD;
                        end
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
               end
               OP_LOAD: begin
                  frame_in = fv_ff;
                  back_in  = rev_ff;
                  up_in    = !rev_ff;
               end
               OP_START: begin
                  held_in = 1'b0;
                  last_in = now_ff;
                  if (!active_ff) begin
                     active_in = 1'b1;
                     done_in   = 1'b0;
                  end
               end
               default: begin
                  held_in = 1'b1;
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  state_in = ST_OUT;
               end else begin
                  last_in  = now_ff;
                  n_in     = n_clamp;
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            frame_in = upd_frame;
            up_in    = upd_up;
            done_in  = upd_done;
            if (upd_done) begin
               active_in = 1'b0;
            end
            chg_in   = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_data_in  = {4'b0000, chg_ff, active_ff, done_ff, up_ff, frame_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL: begin
               interval_in = csr_data;
               acc_in      = '0;
            end
            CSR_TOTAL: begin
               total_in = csr_data;
               acc_in   = '0;
            end
            CSR_LOOP: begin
               loop_in = csr_data[0];
               acc_in  = '0;
            end
            CSR_REBOUND: begin
               reb_in = csr_data[0];
               acc_in = '0;
            end
            CSR_STEP: begin
               step_in = csr_data[0];
               acc_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_ff      <= now_in;
      fv_ff       <= fv_in;
      rev_ff      <= rev_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= '0;
         total_ff     <= '0;
         loop_ff      <= 1'b0;
         reb_ff       <= 1'b0;
         step_ff      <= 1'b1;
         frame_ff     <= '0;
         up_ff        <= 1'b1;
         done_ff      <= 1'b0;
         active_ff    <= 1'b0;
         held_ff      <= 1'b0;
         back_ff      <= 1'b0;
         acc_ff       <= '0;
         last_ff      <= '0;
         chg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         total_ff     <= total_in;
         loop_ff      <= loop_in;
         reb_ff       <= reb_in;
         step_ff      <= step_in;
         frame_ff     <= frame_in;
         up_ff        <= up_in;
         done_ff      <= done_in;
         active_ff    <= active_in;
         held_ff      <= held_in;
         back_ff      <= back_in;
         acc_ff       <= acc_in;
         last_ff      <= last_in;
         chg_ff       <= chg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside of the divide state");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff)
      else $error("finished while still running");

   a_upd_marks_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> (chg_ff && (state_ff == ST_OUT)))
      else $error("frame move not flagged as changed");

   a_out_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_free) |=> (rsp_tvalid && (state_ff == ST_IDLE)))
      else $error("result not presented after completion");

endmodule

>>> tb/sv/animation_frame_sequencer_unit_tb.sv
// self-checking testbench of animation_frame_sequencer_unit: queued request driver,
// result monitor and a cycle-free predictor of frame, direction and done state
// depends on afs_pkg and the animation_frame_sequencer_unit rtl
module animation_frame_sequencer_unit_tb;
   import afs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_STEP + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP   = '1;
   localparam int TIMEOUT     = 20_000_000;
   localparam int TAIL_CYCLES = 60;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic                  wait_drain;
      logic [OP_BITS-1:0]    op;
      logic [TIME_BITS-1:0]  now_ms;
      logic [FRAME_BITS-1:0] frame_value;
      logic                  reverse_flag;
   } anim_req_type;

   typedef struct packed {
      logic                  changed;
      logic                  running;
      logic                  done_res;
      logic                  ascending;
      logic [FRAME_BITS-1:0] frame;
   } anim_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata = '0;
   logic [OP_BITS-1:0]     req_tuser = OP_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_INTERVAL;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predicted configuration and state
   logic [15:0]           p_interval, p_total;
   logic                  p_loop, p_rebound, p_step;
   logic [FRAME_BITS-1:0] p_frame;
   logic                  p_up, p_done, p_active, p_held, p_back;
   logic [ACC_BITS-1:0]   p_accum;
   logic [TIME_BITS-1:0]  p_last_ms;

   anim_req_type pending_reqs[$];
   anim_rsp_type expected_frames[$];
   anim_req_type cur_req;
   anim_rsp_type want_frame, got_frame;
   logic      slot_full = 1'b0;
   logic      steady = 1'b0;
   logic      drain_next = 1'b0;
   int        send_gap = 0;
   int        recv_gap = 0;
   int        mismatches = 0;
   logic [TIME_BITS-1:0] sim_ms = '0;

   animation_frame_sequencer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (steady || r < 8) return 0;
      if (r < 14) return $urandom_range(1, 3);
      if (r < 15) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_INTERVAL: p_interval = val;
         CSR_TOTAL:    p_total = val;
         CSR_LOOP:     p_loop = val[0];
         CSR_REBOUND:  p_rebound = val[0];
         CSR_STEP:     p_step = val[0];
         default: ;
      endcase
      if (idx <= CSR_STEP) p_accum = '0;
   endtask

   function automatic logic advance_frames(input logic [TIME_BITS-1:0] now);
      logic [31:0] n, elapsed, divisor;
      logic [32:0] wide;
      logic [17:0] acc_sum;
      logic        below;
      n = '0;
      below = 1'b0;
      if (p_step) begin
         acc_sum = {1'b0, p_accum} + (ACC_BITS+1)'(TICK_MS);
         p_accum = (acc_sum > ACC_MAX) ? ACC_MAX : acc_sum[ACC_BITS-1:0];
         if (p_accum >= p_interval) begin
            p_accum = '0;
            n = 32'd1;
         end
      end else begin
         elapsed = now - p_last_ms;
         divisor = (p_interval == 0) ? 32'd1 : {16'd0, p_interval};
         n = elapsed / divisor;
         if (n != 0) p_last_ms = now;
      end
      if (n == 0) return 1'b0;

      if (p_up) begin
         wide = {1'b0, n} + p_frame;
         p_frame = (wide > FRAME_MAX) ? FRAME_MAX : wide[FRAME_BITS-1:0];
      end else if (p_frame == 0) begin
         below = 1'b1;
      end else begin
         p_frame = (p_frame > n) ? p_frame - n[FRAME_BITS-1:0] : '0;
      end

      if (p_frame == 0) begin
         if (p_loop && p_rebound) begin
            p_up = 1'b1;
            p_done = 1'b0;
         end else if (p_loop && p_back) begin
            // reverse loop wraps to the top, clamped at zero in time mode
            if (below) begin
               p_up = 1'b0;
               if (p_step) begin
                  p_frame = p_total;
               end else begin
                  wide = {17'd0, p_total} + 33'd1;
                  if (wide > {1'b0, n}) begin
                     wide = wide - {1'b0, n};
                     p_frame = wide[FRAME_BITS-1:0];
                  end else begin
                     p_frame = '0;
                  end
               end
               p_done = 1'b0;
            end
         end else begin
            p_up = 1'b0;
            p_done = 1'b1;
         end
      end else if (p_frame >= p_total) begin
         if (p_loop && p_rebound) begin
            p_up = 1'b0;
            p_frame = p_total;
            p_done = 1'b0;
         end else if (p_loop && !p_back) begin
            if (p_frame > p_total) begin
               p_up = 1'b1;
               p_frame = '0;
               p_done = 1'b0;
            end
         end else begin
            p_up = 1'b1;
            p_frame = p_total;
            p_done = 1'b1;
         end
      end
      if (p_done) p_active = 1'b0;
      return 1'b1;
   endfunction

   function automatic anim_rsp_type next_frame_state(input anim_req_type r);
      anim_rsp_type res;
      logic      moved;
      moved = 1'b0;
      case (r.op)
         OP_TICK: begin
            if (p_active && !p_held) moved = advance_frames(r.now_ms);
         end
         OP_LOAD: begin
            p_frame = r.frame_value;
            p_back = r.reverse_flag;
            p_up = !r.reverse_flag;
         end
         OP_START: begin
            p_held = 1'b0;
            p_last_ms = r.now_ms;
            if (!p_active) begin
               p_active = 1'b1;
               p_done = 1'b0;
            end
         end
         default: p_held = 1'b1;
      endcase
      res.frame = p_frame;
      res.ascending = p_up;
      res.done_res = p_done;
      res.running = p_active;
      res.changed = moved;
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         slot_full = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_frames.push_back(next_frame_state(cur_req));
            slot_full = 1'b0;
         end
         if (!slot_full) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].wait_drain && expected_frames.size() != 0)) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {{(IN_TDATA_W - TIME_BITS - FRAME_BITS - 1){1'b0}},
                             cur_req.reverse_flag, cur_req.frame_value, cur_req.now_ms};
               req_tuser <= cur_req.op;
               slot_full = 1'b1;
               send_gap = pick_gap();
            end
         end
         req_tvalid <= slot_full;
      end
   end

   task automatic check_field(input string name, input logic [FRAME_BITS-1:0] want_v,
                              input logic [FRAME_BITS-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_frame = rsp_tdata[$bits(anim_rsp_type)-1:0];
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want_frame = expected_frames.pop_front();
               check_field("frame", want_frame.frame, got_frame.frame);
               check_field("ascending", want_frame.ascending, got_frame.ascending);
               check_field("done_res", want_frame.done_res, got_frame.done_res);
               check_field("running", want_frame.running, got_frame.running);
               check_field("changed", want_frame.changed, got_frame.changed);
            end
            recv_gap = pick_gap();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_req(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] now,
                           input logic [FRAME_BITS-1:0] fv, input logic rev);
      anim_req_type r;
      r.op = op;
      r.now_ms = now;
      r.frame_value = fv;
      r.reverse_flag = rev;
      r.wait_drain = drain_next || ($urandom_range(0, 63) == 0);
      drain_next = 1'b0;
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || slot_full || expected_frames.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_csr(idx, val);
   endtask

   function automatic logic [TIME_BITS-1:0] time_step();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         2: return $urandom_range(0, 3);
         default: return $urandom_range(0, 3 * p_interval + 2);
      endcase
   endfunction

   task automatic gen_traffic(input int count);
      int left, ticks, k;
      logic [FRAME_BITS-1:0] fv;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            // load, start, then a run of ticks with the odd pause
            case ($urandom_range(0, 5))
               0: fv = '0;
               1: fv = p_total;
               2: fv = FRAME_MAX;
               3: fv = FRAME_BITS'($urandom);
               default: fv = FRAME_BITS'($urandom_range(0, p_total));
            endcase
            push_req(OP_LOAD, $urandom, fv, 1'($urandom_range(0, 1)));
            push_req(OP_START, sim_ms, FRAME_BITS'($urandom), 1'($urandom_range(0, 1)));
            ticks = $urandom_range(1, 24);
            left -= ticks + 2;
            for (k = 0; k < ticks; k++) begin
               sim_ms += time_step();
               if ($urandom_range(0, 19) == 0) begin
                  push_req(OP_PAUSE, $urandom, FRAME_BITS'($urandom),
                           1'($urandom_range(0, 1)));
                  push_req(OP_TICK, sim_ms, FRAME_BITS'($urandom), 1'($urandom_range(0, 1)));
                  push_req(OP_START, sim_ms, FRAME_BITS'($urandom), 1'($urandom_range(0, 1)));
                  left -= 3;
               end
               push_req(OP_TICK, sim_ms, FRAME_BITS'($urandom), 1'($urandom_range(0, 1)));
            end
         end else begin
            push_req(OP_BITS'($urandom_range(0, 3)), $urandom, FRAME_BITS'($urandom),
                     1'($urandom_range(0, 1)));
            left--;
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] ivl, input logic [15:0] tot, input logic lp,
                            input logic rb, input logic st, input int count);
      logic [CSR_DATA_W-1:0] junk;
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_INTERVAL, ivl);
      write_csr(CSR_TOTAL, tot);
      write_csr(CSR_LOOP, {junk[15:1], lp});
      write_csr(CSR_REBOUND, {junk[14:0], rb});
      write_csr(CSR_STEP, {junk[13:0], junk[15], st});
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE, CSR_TOP)), CSR_DATA_W'($urandom));
      end
      gen_traffic(count);
   endtask

   initial begin
      int ph;
      p_interval = '0;
      p_total = '0;
      p_loop = 1'b0;
      p_rebound = 1'b0;
      p_step = 1'b1;
      p_frame = '0;
      p_up = 1'b1;
      p_done = 1'b0;
      p_active = 1'b0;
      p_held = 1'b0;
      p_back = 1'b0;
      p_accum = '0;
      p_last_ms = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: step mode, zero interval, zero total
      push_req(OP_TICK, 32'd0, 16'd0, 1'b0);
      push_req(OP_PAUSE, 32'd0, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd0, 16'd0, 1'b0);
      push_req(OP_START, 32'd0, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd0, 16'd0, 1'b0);
      push_req(OP_START, 32'hFFFF_FFFF, FRAME_MAX, 1'b1);
      push_req(OP_LOAD, 32'hFFFF_FFFF, FRAME_MAX, 1'b0);
      push_req(OP_TICK, 32'hFFFF_FFFF, FRAME_MAX, 1'b1);
      push_req(OP_START, 32'hFFFF_FFFF, 16'd0, 1'b0);
      push_req(OP_LOAD, 32'd0, 16'd5, 1'b1);
      push_req(OP_PAUSE, 32'd0, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd0, 16'd0, 1'b0);
      push_req(OP_START, 32'd7, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd9, 16'd0, 1'b0);

      // time mode, divide by one, full total, forward and reverse loop
      wait_idle();
      write_csr(CSR_TOTAL, FRAME_MAX);
      write_csr(CSR_LOOP, 16'd1);
      write_csr(CSR_STEP, 16'd0);
      push_req(OP_LOAD, 32'd0, 16'd0, 1'b0);
      push_req(OP_START, 32'd0, 16'd0, 1'b0);
      drain_next = 1'b1;
      push_req(OP_TICK, 32'hFFFF_FFFF, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd0, 16'd0, 1'b0);
      push_req(OP_LOAD, 32'd0, 16'd1, 1'b1);
      push_req(OP_START, 32'd100, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd105, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd107, 16'd0, 1'b0);

      // rebound at both ends
      wait_idle();
      write_csr(CSR_REBOUND, 16'd1);
      write_csr(CSR_TOTAL, 16'd3);
      write_csr(CSR_INTERVAL, 16'd2);
      push_req(OP_LOAD, 32'd0, 16'd2, 1'b0);
      push_req(OP_START, 32'd0, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd2, 16'd0, 1'b0);
      push_req(OP_TICK, 32'd10, 16'd0, 1'b0);

      run_phase(16'd0, 16'd0, 1'b0, 1'b0, 1'b1, PHASE_ITEMS);
      run_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, PHASE_ITEMS);
      run_phase(16'd1, 16'hFFFF, 1'b1, 1'b0, 1'b0, PHASE_ITEMS);
      run_phase(16'hFFFF, 16'd3, 1'b1, 1'b1, 1'b0, PHASE_ITEMS);
      run_phase(16'd0, 16'd5, 1'b1, 1'b0, 1'b0, PHASE_ITEMS);
      run_phase(16'd20, 16'd6, 1'b1, 1'b0, 1'b1, PHASE_ITEMS);
      for (ph = 0; ph < 7; ph++) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            steady = ($urandom_range(0, 3) == 0);
            write_csr(CSR_IDX_W'($urandom_range(0, CSR_TOP)), CSR_DATA_W'($urandom));
            gen_traffic(PHASE_ITEMS);
         end else begin
            run_phase(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), PHASE_ITEMS);
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT);
      $display("FAIL");
      $finish;
   end

endmodule
